FILE: src/wrs_pkg.sv
// ----------------------------------------------------------------------------
// wrs_pkg
// shared widths, limits and control types of the running statistics block
// ----------------------------------------------------------------------------
`default_nettype none

package wrs_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int COUNT_BITS  = 21;
   localparam int MEAN_BITS   = 32;
   localparam int SUM_BITS    = 64;
   localparam int STDEV_BITS  = 16;
   localparam int DIVISOR_BITS = COUNT_BITS;
   localparam int STEP_BITS   = 7;

   localparam logic [COUNT_BITS-1:0] MAX_ITEMS = COUNT_BITS'(1048576);

   // steps of the shared divider for the two divisions
   localparam logic [STEP_BITS-1:0] MEAN_DIV_STEPS = STEP_BITS'(33);
   localparam logic [STEP_BITS-1:0] VAR_DIV_STEPS  = STEP_BITS'(64);

   typedef struct packed {
      logic                    start;
      logic [STEP_BITS-1:0]    steps;
      logic [SUM_BITS-1:0]     dividend;
      logic [DIVISOR_BITS-1:0] divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic                done;
      logic [SUM_BITS-1:0] quotient;
   } div_stat_type;

endpackage

`default_nettype wire

FILE: src/wrs_if.sv
// ----------------------------------------------------------------------------
// wrs_req_if / wrs_rsp_if
// valid/ready channels for sample words and result words
// ----------------------------------------------------------------------------
`default_nettype none

interface wrs_req_if
   import wrs_pkg::*;
();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          is_missing;
   logic                          last_sample;

   modport source (output valid, sample, is_missing, last_sample, input ready);
   modport sink   (input valid, sample, is_missing, last_sample, output ready);
endinterface

interface wrs_rsp_if
   import wrs_pkg::*;
();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] min_value;
   logic signed [SAMPLE_BITS-1:0] max_value;
   logic signed [MEAN_BITS-1:0]   mean_value;
   logic [STDEV_BITS-1:0]         stdev_value;
   logic [COUNT_BITS-1:0]         finite_count;
   logic [COUNT_BITS-1:0]         missing_count;
   logic                          overflow;

   modport source (output valid, min_value, max_value, mean_value, stdev_value,
                   finite_count, missing_count, overflow, input ready);
   modport sink   (input valid, min_value, max_value, mean_value, stdev_value,
                   finite_count, missing_count, overflow, output ready);
endinterface

`default_nettype wire

FILE: src/welford_running_statistics.sv
// ----------------------------------------------------------------------------
// welford_running_statistics
// running min, max, mean and sample standard deviation over a column
// ----------------------------------------------------------------------------
// req channel: one sample word per handshake (Q8.8 sample, missing flag,
//    last flag). rsp channel: one result word per column, sent after the
//    word with last_sample set.
// a missing or ignored sample is taken in its accept cycle alone. a finite
//    sample passes the accept cycle, the mean division in the shared
//    radix-2 divider, the mean update, the bit-serial square-term multiply
//    and the addition of the term.
// with more than one finite sample in the column, the last word then adds
//    the variance division (64 divider steps), the square root and the load
//    of the result register; with one or no finite samples the result
//    register is loaded without the variance division and the square root.
// req.ready is high only while the block is idle; the result sits in an
//    output register, so a stalled receiver only holds the block when the
//    next result is finished and the previous one is still not taken.
// reset (synchronous) clears all statistics and drops rsp.valid.
// ----------------------------------------------------------------------------
`default_nettype none

module welford_running_statistics
   import wrs_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   wrs_req_if.sink   req_ch,
   wrs_rsp_if.source rsp_ch
);

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_MUL, S_VAR, S_SQRT, S_OUT
   } state_type;

   localparam int DELTA_BITS = MEAN_BITS + 2;
   localparam int MAG_BITS   = MEAN_BITS + 1;
   localparam int FAC_BITS   = MAG_BITS - 8;
   localparam int PROD_BITS  = 2 * FAC_BITS;

   state_type                     state_ff;
   logic signed [SAMPLE_BITS-1:0] min_ff, max_ff;
   logic signed [MEAN_BITS-1:0]   mean_ff;
   logic [SUM_BITS-1:0]           sq_ff;
   logic [COUNT_BITS-1:0]         n_ff, miss_ff;
   logic                          ovf_ff;
   logic                          last_ff;
   logic signed [DELTA_BITS-1:0]  xm_ff;
   logic                          neg_ff;
   logic [PROD_BITS-1:0]          a_ff, acc_ff;
   logic [FAC_BITS-1:0]           b_ff;
   logic [5:0]                    cnt_ff;
   logic [SUM_BITS-1:0]           v_ff, r_ff, bit_ff;
   logic [STDEV_BITS-1:0]         stdev_ff;

   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_min_ff, rsp_max_ff;
   logic signed [MEAN_BITS-1:0]   rsp_mean_ff;
   logic [STDEV_BITS-1:0]         rsp_stdev_ff;
   logic [COUNT_BITS-1:0]         rsp_fin_ff, rsp_miss_ff;
   logic                          rsp_ovf_ff;

   div_ctrl_type div_ctrl;
   div_stat_type div_stat;

   // combinational helpers
   logic signed [DELTA_BITS-1:0] xm, delta, qs, mean_new, delta2;
   logic [MAG_BITS-1:0]          mag1, mag2;
   logic [SUM_BITS-1:0]          rb;
   logic                         accept;

   // first square-term factor: delta2 magnitude over 2^8
   function automatic logic [PROD_BITS-1:0] delta2_factor(
      input logic [MAG_BITS-1:0] m
   );
      delta2_factor = PROD_BITS'(m >> 8);
   endfunction

   // second factor: original delta magnitude over 2^8, rebuilt from the
   // stored scaled sample and the mean before its update
   function automatic logic [FAC_BITS-1:0] delta_factor(
      input logic signed [DELTA_BITS-1:0] xs,
      input logic signed [MEAN_BITS-1:0]  m
   );
      logic signed [DELTA_BITS-1:0] d;
      logic [MAG_BITS-1:0]          dm;
      d  = xs - DELTA_BITS'(m);
      dm = d[DELTA_BITS-1] ? MAG_BITS'(-d) : MAG_BITS'(d);
      delta_factor = FAC_BITS'(dm >> 8);
   endfunction

   assign accept = req_ch.valid && req_ch.ready;
   assign xm     = DELTA_BITS'(req_ch.sample) <<< 16;
   assign delta  = xm - DELTA_BITS'(mean_ff);
   assign mag1   = delta[DELTA_BITS-1] ? MAG_BITS'(-delta) : MAG_BITS'(delta);

   // mean update from the divider quotient, truncated toward zero
   assign qs       = neg_ff ? -DELTA_BITS'(div_stat.quotient[MAG_BITS-1:0])
                            : DELTA_BITS'(div_stat.quotient[MAG_BITS-1:0]);
   assign mean_new = DELTA_BITS'(mean_ff) + qs;
   assign delta2   = xm_ff - mean_new;
   assign mag2     = delta2[DELTA_BITS-1] ? MAG_BITS'(-delta2) : MAG_BITS'(delta2);
   assign rb       = r_ff + bit_ff;

   always_comb begin
      div_ctrl = '0;
      if (state_ff == S_IDLE && accept && !req_ch.is_missing && n_ff < MAX_ITEMS) begin
         div_ctrl.start    = 1'b1;
         div_ctrl.steps    = MEAN_DIV_STEPS;
         div_ctrl.dividend = SUM_BITS'(mag1) << (SUM_BITS - MAG_BITS);
         div_ctrl.divisor  = n_ff + COUNT_BITS'(1);
      end else if (state_ff == S_VAR && cnt_ff == '0) begin
         div_ctrl.start    = 1'b1;
         div_ctrl.steps    = VAR_DIV_STEPS;
         div_ctrl.dividend = sq_ff;
         div_ctrl.divisor  = n_ff - COUNT_BITS'(1);
      end
   end

   wrs_divider u_div (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .stat  (div_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         min_ff       <= '0;
         max_ff       <= '0;
         mean_ff      <= '0;
         sq_ff        <= '0;
         n_ff         <= '0;
         miss_ff      <= '0;
         ovf_ff       <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         // result word taken and no new one loaded this cycle
         if (rsp_valid_ff && rsp_ch.ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  last_ff  <= req_ch.last_sample;
                  stdev_ff <= '0;
                  cnt_ff   <= '0;
                  if (req_ch.is_missing) begin
                     if (miss_ff < MAX_ITEMS) begin
                        miss_ff <= miss_ff + COUNT_BITS'(1);
                     end
                     if (req_ch.last_sample) begin
                        state_ff <= (n_ff > COUNT_BITS'(1)) ? S_VAR : S_OUT;
                     end
                  end else if (n_ff >= MAX_ITEMS) begin
                     ovf_ff <= 1'b1;
                     if (req_ch.last_sample) begin
                        state_ff <= (n_ff > COUNT_BITS'(1)) ? S_VAR : S_OUT;
                     end
                  end else begin
                     if (n_ff == '0 || req_ch.sample < min_ff) begin
                        min_ff <= req_ch.sample;
                     end
                     if (n_ff == '0 || req_ch.sample > max_ff) begin
                        max_ff <= req_ch.sample;
                     end
                     n_ff     <= n_ff + COUNT_BITS'(1);
                     xm_ff    <= xm;
                     neg_ff   <= delta[DELTA_BITS-1];
                     state_ff <= S_DIV;
                  end
               end
            end
            S_DIV: begin
               if (div_stat.done) begin
                  mean_ff  <= MEAN_BITS'(mean_new);
                  a_ff     <= delta2_factor(mag2);
                  b_ff     <= delta_factor(xm_ff, mean_ff);
                  acc_ff   <= '0;
                  cnt_ff   <= 6'(FAC_BITS);
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               // shift-add, one multiplier bit per cycle
               if (cnt_ff == '0) begin
                  sq_ff <= sq_ff + SUM_BITS'(acc_ff >> 16);
                  if (last_ff) begin
                     state_ff <= (n_ff > COUNT_BITS'(1)) ? S_VAR : S_OUT;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end else begin
                  if (b_ff[0]) begin
                     acc_ff <= acc_ff + a_ff;
                  end
                  a_ff   <= a_ff << 1;
                  b_ff   <= b_ff >> 1;
                  cnt_ff <= cnt_ff - 6'd1;
               end
            end
            S_VAR: begin
               // first cycle starts the divider, then wait for the quotient
               if (div_stat.done) begin
                  v_ff     <= div_stat.quotient;
                  r_ff     <= '0;
                  bit_ff   <= SUM_BITS'(1) << (SUM_BITS - 2);
                  cnt_ff   <= 6'd32;
                  state_ff <= S_SQRT;
               end else begin
                  cnt_ff <= 6'd1;
               end
            end
            S_SQRT: begin
               if (cnt_ff == '0) begin
                  stdev_ff <= (r_ff > SUM_BITS'(16'hFFFF)) ? 16'hFFFF
                                                           : r_ff[STDEV_BITS-1:0];
                  state_ff <= S_OUT;
               end else begin
                  if (v_ff >= rb) begin
                     v_ff <= v_ff - rb;
                     r_ff <= (r_ff >> 1) + bit_ff;
                  end else begin
                     r_ff <= r_ff >> 1;
                  end
                  bit_ff <= bit_ff >> 2;
                  cnt_ff <= cnt_ff - 6'd1;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_min_ff   <= min_ff;
                  rsp_max_ff   <= max_ff;
                  rsp_mean_ff  <= mean_ff;
                  rsp_stdev_ff <= stdev_ff;
                  rsp_fin_ff   <= n_ff;
                  rsp_miss_ff  <= miss_ff;
                  rsp_ovf_ff   <= ovf_ff;
                  min_ff       <= '0;
                  max_ff       <= '0;
                  mean_ff      <= '0;
                  sq_ff        <= '0;
                  n_ff         <= '0;
                  miss_ff      <= '0;
                  ovf_ff       <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ch.ready         = (state_ff == S_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.min_value     = rsp_min_ff;
   assign rsp_ch.max_value     = rsp_max_ff;
   assign rsp_ch.mean_value    = rsp_mean_ff;
   assign rsp_ch.stdev_value   = rsp_stdev_ff;
   assign rsp_ch.finite_count  = rsp_fin_ff;
   assign rsp_ch.missing_count = rsp_miss_ff;
   assign rsp_ch.overflow      = rsp_ovf_ff;

endmodule

`default_nettype wire

FILE: src/wrs_divider.sv
// ----------------------------------------------------------------------------
// wrs_divider
// restoring radix-2 divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module wrs_divider
   import wrs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire div_ctrl_type ctrl,
   output      div_stat_type stat
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [STEP_BITS-1:0]    cnt_ff, cnt_in;
   logic [DIVISOR_BITS:0]   rem_ff, rem_in;
   logic [SUM_BITS-1:0]     quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0] div_ff, div_in;
   logic [DIVISOR_BITS:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      trial   = {rem_ff[DIVISOR_BITS-1:0], quo_ff[SUM_BITS-1]};
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = ctrl.steps;
         rem_in  = '0;
         quo_in  = ctrl.dividend;
         div_in  = ctrl.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - STEP_BITS'(1);
         if (cnt_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff;

endmodule

`default_nettype wire

FILE: tb/tb_wrs_checker.sv
// ----------------------------------------------------------------------------
// tb_wrs_checker
// watches the sample and result channels, predicts column statistics and
// compares every result word field by field
// ----------------------------------------------------------------------------
`default_nettype none

module tb_wrs_checker
   import wrs_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   wrs_req_if.sink   req_mon,
   wrs_rsp_if.sink   rsp_mon,
   output int        fail_count,
   output int        pending_count,
   output int        result_count
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] min_value;
      logic signed [SAMPLE_BITS-1:0] max_value;
      logic signed [MEAN_BITS-1:0]   mean_value;
      logic [STDEV_BITS-1:0]         stdev_value;
      logic [COUNT_BITS-1:0]         finite_count;
      logic [COUNT_BITS-1:0]         missing_count;
      logic                          overflow;
   } col_stats_type;

   // column accumulators
   longint signed   col_min, col_max, col_mean;
   longint unsigned col_sq_sum, col_finite, col_missing;
   bit              col_overflow;

   col_stats_type stats_queue[$];

   function automatic longint unsigned abs64(longint signed v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   task automatic clear_column();
      col_min = 0; col_max = 0; col_mean = 0; col_sq_sum = 0;
      col_finite = 0; col_missing = 0; col_overflow = 0;
   endtask

   task automatic absorb_sample(logic signed [SAMPLE_BITS-1:0] s, logic miss, logic lst);
      longint signed   x, xm, d1, d2;
      longint unsigned sd;
      col_stats_type   r;
      x = s;
      if (miss) begin
         if (col_missing < MAX_ITEMS) col_missing++;
      end else if (col_finite >= MAX_ITEMS) begin
         col_overflow = 1;
      end else begin
         if (col_finite == 0) begin
            col_min = x; col_max = x;
         end else begin
            if (x < col_min) col_min = x;
            if (x > col_max) col_max = x;
         end
         col_finite++;
         xm = x * 65536;
         d1 = xm - col_mean;
         col_mean = col_mean + d1 / longint'(col_finite);
         d2 = xm - col_mean;
         col_sq_sum += ((abs64(d1) >> 8) * (abs64(d2) >> 8)) >> 16;
      end
      if (lst) begin
         sd = 0;
         if (col_finite > 1) begin
            sd = int_sqrt(col_sq_sum / (col_finite - 1));
            if (sd > 65535) sd = 65535;
         end
         if (col_finite == 0) begin
            r.min_value = 0; r.max_value = 0; r.mean_value = 0; r.stdev_value = 0;
         end else begin
            r.min_value = col_min[15:0];
            r.max_value = col_max[15:0];
            r.mean_value = col_mean[31:0];
            r.stdev_value = sd[15:0];
         end
         r.finite_count = col_finite[COUNT_BITS-1:0];
         r.missing_count = col_missing[COUNT_BITS-1:0];
         r.overflow = col_overflow;
         stats_queue.insert(stats_queue.size(), r);
         clear_column();
      end
   endtask

   task automatic report(string what, longint unsigned exp_v, longint unsigned act_v);
      $display("%0t mismatch %s: expected %0h actual %0h", $time, what, exp_v, act_v);
      fail_count++;
   endtask

   always @(posedge clock) begin
      col_stats_type e;
      if (reset) begin
         clear_column();
         stats_queue.delete();
         fail_count = 0;
         result_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            result_count++;
            if (stats_queue.size() == 0) begin
               $display("%0t mismatch: result word with nothing expected", $time);
               fail_count++;
            end else begin
               e = stats_queue.pop_front();
               if (e.min_value !== rsp_mon.min_value)
                  report("min", 16'(e.min_value), 16'(rsp_mon.min_value));
               if (e.max_value !== rsp_mon.max_value)
                  report("max", 16'(e.max_value), 16'(rsp_mon.max_value));
               if (e.mean_value !== rsp_mon.mean_value)
                  report("mean", 32'(e.mean_value), 32'(rsp_mon.mean_value));
               if (e.stdev_value !== rsp_mon.stdev_value)
                  report("stdev", e.stdev_value, rsp_mon.stdev_value);
               if (e.finite_count !== rsp_mon.finite_count)
                  report("finite", e.finite_count, rsp_mon.finite_count);
               if (e.missing_count !== rsp_mon.missing_count)
                  report("missing", e.missing_count, rsp_mon.missing_count);
               if (e.overflow !== rsp_mon.overflow)
                  report("overflow", e.overflow, rsp_mon.overflow);
            end
         end
         if (req_mon.valid && req_mon.ready)
            absorb_sample(req_mon.sample, req_mon.is_missing, req_mon.last_sample);
      end
      pending_count = stats_queue.size();
   end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the running statistics block: directed columns,
// then random columns with bursty sender and stalling receiver
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_WORDS = 700;
   localparam int IDLE_LIMIT   = 20000;

   logic clock;
   logic reset;
   int   fail_count, pending_count, result_count;
   int   words_sent;
   bit   long_hold;     // receiver held off for a long stretch
   int   idle_cycles;

   wrs_req_if req_ch();
   wrs_rsp_if rsp_ch();

   welford_running_statistics i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   tb_wrs_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch.sink),
      .rsp_mon       (rsp_ch.sink),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // burst state of the sender
   int burst_left;

   // offer one word and hold it until accepted; gaps come between bursts
   task automatic send_word(logic signed [15:0] s, logic miss, logic lst);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         // some bursts run back to back with no gap
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_ch.valid       <= 1'b1;
      req_ch.sample      <= s;
      req_ch.is_missing  <= miss;
      req_ch.last_sample <= lst;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   // random column; mostly finite words, sometimes narrow ranges for small variance
   task automatic send_column(int len);
      int   mode;
      logic signed [15:0] base, s;
      mode = $urandom_range(0, 3);
      base = 16'($urandom);
      for (int k = 0; k < len; k++) begin
         case (mode)
            0:       s = 16'($urandom);
            1:       s = base + 16'($signed($urandom_range(0, 64)) - 32);
            2:       s = ($urandom_range(0, 1)) ? 16'sh7fff : -16'sh8000;
            default: s = 16'($signed($urandom_range(0, 2048)) - 1024);
         endcase
         send_word(s, $urandom_range(0, 7) == 0, k == len - 1);
      end
   endtask

   // receiver: own stall pattern, plus one long hold-off
   initial begin
      int phase;
      rsp_ch.ready = 1'b0;
      phase = 0;
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            phase = (phase + 1) % 29;
            // ready runs free for part of the pattern, stalls randomly elsewhere
            rsp_ch.ready <= (phase < 12) ? 1'b1 : ($urandom_range(0, 2) != 0);
         end
      end
   end

   // watchdog on cycles without any handshake
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("[welford_running_statistics] ERROR");
            $finish;
         end
      end
   end

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.sample      = '0;
      req_ch.is_missing  = 1'b0;
      req_ch.last_sample = 1'b0;
      reset      = 1'b1;
      words_sent = 0;
      burst_left = 0;
      long_hold  = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, single sample, empty column, constant column
      send_word(16'sh7fff, 0, 0);
      send_word(-16'sh8000, 0, 1);
      send_word(16'sh0100, 0, 1);              // one finite sample, zero stdev
      send_word(16'sh1234, 1, 1);              // no finite samples at all
      send_word(16'sh0000, 1, 0);
      send_word(16'sh0042, 0, 0);
      send_word(-16'sh0001, 1, 1);             // last flag on a missing word
      for (int k = 0; k < 4; k++) send_word(16'sh0280, 0, k == 3);  // zero variance
      send_word(-16'sh8000, 0, 0);
      send_word(-16'sh8000, 0, 0);
      send_word(16'sh7fff, 0, 0);
      send_word(16'sh7fff, 0, 1);              // large spread
      send_word(16'sh5555, 0, 0);
      send_word(-16'sh5556, 0, 0);
      send_word(16'sh0001, 0, 1);

      // pressure: receiver held off while columns keep coming
      long_hold = 1;
      fork
         begin
            repeat (3) send_column($urandom_range(1, 3));
         end
         begin
            repeat (1500) @(posedge clock);
         end
      join_any
      long_hold = 0;
      wait fork;

      // random columns, mostly short
      while (words_sent < RANDOM_WORDS)
         send_column(($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                 : $urandom_range(1, 6));
      req_ch.valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);

      $display("sent %0d sample words, checked %0d column results", words_sent,
               result_count);
      $display("covered extremes, empty and single-sample columns, missing words");
      if (fail_count == 0)
         $display("[welford_running_statistics] OK");
      else
         $display("[welford_running_statistics] ERROR");
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
src/wrs_pkg.sv
src/wrs_if.sv
src/wrs_divider.sv
src/welford_running_statistics.sv
tb/tb_wrs_checker.sv
tb/tb_top.sv
